// ----- rtl/core/nmkp_pkg.sv -----
// shared constants, types and codes for the next multiset k-permutation block
package nmkp_pkg;

   // array geometry
   localparam int MaxElements = 64;
   localparam int AddrW       = $clog2(MaxElements);
   localparam int SymW        = 6;
   localparam int CntW        = 7;

   // request operations
   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_ADVANCE = 1'b1;

   // register indexes, decoded from the word address
   localparam logic REG_TOTAL_COUNT   = 1'b0;
   localparam logic REG_PREFIX_LENGTH = 1'b1;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_REV_RD,
      ST_SWAP_A,
      ST_SWAP_B,
      ST_ASC_RD,
      ST_ASC_CMP,
      ST_PIV_RD,
      ST_PIV_CMP,
      ST_EMIT_RD,
      ST_EMIT_OUT,
      ST_EXH_OUT
   } state_type;

   // which step a swap or reversal belongs to
   typedef enum logic [1:0] {
      PH_EDGE,
      PH_REV1,
      PH_PIVOT,
      PH_REV2
   } phase_type;

   // symbol memory access: write port and both read ports
   typedef struct packed {
      logic             we;
      logic [AddrW-1:0] waddr;
      logic [SymW-1:0]  wdata;
      logic             re;
      logic [AddrW-1:0] raddr0;
      logic [AddrW-1:0] raddr1;
   } mem_req_type;

endpackage

// ----- rtl/core/nmkp_mem.sv -----
// symbol memory: one write port, two registered read ports
module nmkp_mem (
   input  logic                      clock,
   input  nmkp_pkg::mem_req_type     mem_req,
   output logic [nmkp_pkg::SymW-1:0] rd0,
   output logic [nmkp_pkg::SymW-1:0] rd1
);
   import nmkp_pkg::*;

   logic [SymW-1:0] mem_ff [MaxElements];
   logic [SymW-1:0] rd0_ff;
   logic [SymW-1:0] rd1_ff;

   // write port
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.waddr] <= mem_req.wdata;
      end
   end

   // read ports hold their data until the next read
   always_ff @(posedge clock) begin
      if (mem_req.re) begin
         rd0_ff <= mem_ff[mem_req.raddr0];
         rd1_ff <= mem_ff[mem_req.raddr1];
      end
   end

   assign rd0 = rd0_ff;
   assign rd1 = rd1_ff;

endmodule

// ----- rtl/core/next_multiset_k_permutation.sv -----
// top level: next k-permutation of a stored multiset in lexicographic order
//
// Usage. Requests arrive on req_* (valid/stall). A load request (op 0) writes
// load_symbol to array position load_position and produces no response; it
// is taken only while idle. An advance request (op 1) moves the first k entries
// to the next k-permutation and then returns k responses on rsp_*, positions
// 0..k-1, with last set on the final one; if none exists it returns a single
// response with exhausted and last set. n and k come from the registers
// total_count and prefix_length over the APB-style port and are clipped to
// 1..64 and 1..n when an advance starts.
// Timing. All array work goes through one symbol memory with two read ports
// and one write port, one access step per cycle while no response stalls: the
// tail scan reads and compares each element, every swap of a reversal reads
// both ends and writes them back in turn, the ascent and pivot searches read
// and compare per element and the output reads each symbol before sending it.
// One request is worked on at a time; req_stall is high until the last
// response of an advance has been taken.
// Reset clears the sequencer and sets both registers to 64; the array itself
// is not cleared and holds unknown data until loaded. A stalled response is
// held unchanged, and the sequencer waits for it.
module next_multiset_k_permutation (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [5:0]  req_load_position,
   input  logic [5:0]  req_load_symbol,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_position,
   output logic [5:0]  rsp_symbol,
   output logic        rsp_last,
   output logic        rsp_exhausted,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import nmkp_pkg::*;

   state_type        state_ff, state_in;
   phase_type        phase_ff, phase_in;
   logic [CntW-1:0]  total_count_ff, prefix_length_ff;
   logic [CntW-1:0]  n_ff, n_in, k_ff, k_in;
   logic [CntW-1:0]  n_sat, k_sat;
   logic [AddrW-1:0] i_ff, i_in, j_ff, j_in, p_ff, p_in;
   logic [CntW-1:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic [AddrW-1:0] swap_x, swap_y;
   logic [SymW-1:0]  rd0, rd1;
   logic             req_take, csr_write, rev_more, emit_last;
   mem_req_type      mem_req;

   // register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_count_ff   <= CntW'(MaxElements);
         prefix_length_ff <= CntW'(MaxElements);
      end else if (csr_write) begin
         if (paddr[2] == REG_TOTAL_COUNT) begin
            total_count_ff <= pwdata[CntW-1:0];
         end else begin
            prefix_length_ff <= pwdata[CntW-1:0];
         end
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_PREFIX_LENGTH) begin
         prdata[CntW-1:0] = prefix_length_ff;
      end else begin
         prdata[CntW-1:0] = total_count_ff;
      end
   end

   // clip n and k for the advance about to start
   always_comb begin
      n_sat = total_count_ff;
      if (total_count_ff == '0) begin
         n_sat = CntW'(1);
      end else if (total_count_ff > CntW'(MaxElements)) begin
         n_sat = CntW'(MaxElements);
      end
      k_sat = prefix_length_ff;
      if (prefix_length_ff == '0) begin
         k_sat = CntW'(1);
      end else if (prefix_length_ff > n_sat) begin
         k_sat = n_sat;
      end
   end

   // handshake helpers
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rev_more  = (lo_ff + CntW'(1)) < hi_ff;
   assign emit_last = ({1'b0, p_ff} + CntW'(1)) == k_ff;

   // swap operands per step
   always_comb begin
      case (phase_ff)
         PH_EDGE: begin
            swap_x = AddrW'(k_ff - CntW'(1));
            swap_y = j_ff;
         end
         PH_PIVOT: begin
            swap_x = i_ff;
            swap_y = j_ff;
         end
         default: begin
            swap_x = lo_ff[AddrW-1:0];
            swap_y = AddrW'(hi_ff - CntW'(1));
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && req_op == OP_ADVANCE) begin
               if (k_sat < n_sat) begin
                  state_in = ST_SCAN_RD;
               end else if (k_sat < CntW'(2)) begin
                  state_in = ST_EXH_OUT;
               end else begin
                  state_in = ST_ASC_RD;
               end
            end
         end
         ST_SCAN_RD: state_in = ST_SCAN_CMP;
         ST_SCAN_CMP: begin
            if (rd1 > rd0) begin
               state_in = ST_SWAP_A;
            end else if (({1'b0, j_ff} + CntW'(1)) == n_ff) begin
               state_in = ST_REV_RD;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_REV_RD: begin
            if (rev_more) begin
               state_in = ST_SWAP_A;
            end else if (phase_ff == PH_REV1) begin
               state_in = (k_ff < CntW'(2)) ? ST_EXH_OUT : ST_ASC_RD;
            end else begin
               state_in = ST_EMIT_RD;
            end
         end
         ST_SWAP_A: state_in = ST_SWAP_B;
         ST_SWAP_B: begin
            state_in = (phase_ff == PH_EDGE) ? ST_EMIT_RD : ST_REV_RD;
         end
         ST_ASC_RD: state_in = ST_ASC_CMP;
         ST_ASC_CMP: begin
            if (rd0 < rd1) begin
               state_in = ST_PIV_RD;
            end else if (i_ff == '0) begin
               state_in = ST_EXH_OUT;
            end else begin
               state_in = ST_ASC_RD;
            end
         end
         ST_PIV_RD: state_in = ST_PIV_CMP;
         ST_PIV_CMP: begin
            state_in = (rd0 >= rd1) ? ST_PIV_RD : ST_SWAP_A;
         end
         ST_EMIT_RD: state_in = ST_EMIT_OUT;
         ST_EMIT_OUT: begin
            if (!rsp_stall) begin
               state_in = emit_last ? ST_IDLE : ST_EMIT_RD;
            end
         end
         ST_EXH_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath updates, memory accesses and responses
   always_comb begin
      phase_in       = phase_ff;
      n_in           = n_ff;
      k_in           = k_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      p_in           = p_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      mem_req        = '0;
      rsp_valid      = 1'b0;
      rsp_position   = p_ff;
      rsp_symbol     = rd0;
      rsp_last       = emit_last;
      rsp_exhausted  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && req_op == OP_LOAD) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = req_load_position;
               mem_req.wdata = req_load_symbol;
            end else if (req_take) begin
               n_in     = n_sat;
               k_in     = k_sat;
               j_in     = AddrW'(k_sat);
               i_in     = AddrW'(k_sat - CntW'(2));
               phase_in = PH_EDGE;
            end
         end
         ST_SCAN_RD: begin
            mem_req.re     = 1'b1;
            mem_req.raddr0 = AddrW'(k_ff - CntW'(1));
            mem_req.raddr1 = j_ff;
         end
         ST_SCAN_CMP: begin
            if (!(rd1 > rd0)) begin
               j_in = j_ff + AddrW'(1);
               if (({1'b0, j_ff} + CntW'(1)) == n_ff) begin
                  phase_in = PH_REV1;
                  lo_in    = k_ff;
                  hi_in    = n_ff;
                  i_in     = AddrW'(k_ff - CntW'(2));
               end
            end
         end
         ST_REV_RD: begin
            mem_req.re     = 1'b1;
            mem_req.raddr0 = lo_ff[AddrW-1:0];
            mem_req.raddr1 = AddrW'(hi_ff - CntW'(1));
            p_in           = '0;
         end
         ST_SWAP_A: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = swap_x;
            mem_req.wdata = rd1;
         end
         ST_SWAP_B: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = swap_y;
            mem_req.wdata = rd0;
            p_in          = '0;
            if (phase_ff == PH_PIVOT) begin
               phase_in = PH_REV2;
               lo_in    = {1'b0, i_ff} + CntW'(1);
               hi_in    = n_ff;
            end else if (phase_ff != PH_EDGE) begin
               lo_in = lo_ff + CntW'(1);
               hi_in = hi_ff - CntW'(1);
            end
         end
         ST_ASC_RD: begin
            mem_req.re     = 1'b1;
            mem_req.raddr0 = i_ff;
            mem_req.raddr1 = i_ff + AddrW'(1);
         end
         ST_ASC_CMP: begin
            if (rd0 < rd1) begin
               j_in     = AddrW'(n_ff - CntW'(1));
               phase_in = PH_PIVOT;
            end else if (i_ff != '0) begin
               i_in = i_ff - AddrW'(1);
            end
         end
         ST_PIV_RD: begin
            mem_req.re     = 1'b1;
            mem_req.raddr0 = i_ff;
            mem_req.raddr1 = j_ff;
         end
         ST_PIV_CMP: begin
            if (rd0 >= rd1) begin
               j_in = j_ff - AddrW'(1);
            end
         end
         ST_EMIT_RD: begin
            mem_req.re     = 1'b1;
            mem_req.raddr0 = p_ff;
            mem_req.raddr1 = p_ff;
         end
         ST_EMIT_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               p_in = p_ff + AddrW'(1);
            end
         end
         ST_EXH_OUT: begin
            rsp_valid     = 1'b1;
            rsp_position  = '0;
            rsp_symbol    = '0;
            rsp_last      = 1'b1;
            rsp_exhausted = 1'b1;
         end
         default: begin
            rsp_valid = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_EDGE;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   // working indexes
   always_ff @(posedge clock) begin
      n_ff  <= n_in;
      k_ff  <= k_in;
      i_ff  <= i_in;
      j_ff  <= j_in;
      p_ff  <= p_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end

   // symbol memory
   nmkp_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd0     (rd0),
      .rd1     (rd1)
   );

   // checks
   property p_exhausted_alone;
      @(posedge clock) disable iff (reset)
         (rsp_valid && rsp_exhausted) |-> (rsp_last && rsp_position == '0);
   endproperty
   a_exhausted_alone: assert property (p_exhausted_alone)
      else $error("exhausted response not marked last at position zero");

   property p_no_request_while_responding;
      @(posedge clock) disable iff (reset)
         rsp_valid |-> req_stall;
   endproperty
   a_no_request_while_responding: assert property (p_no_request_while_responding)
      else $error("request taken while a response is pending");

   property p_no_read_write_overlap;
      @(posedge clock) disable iff (reset)
         !(mem_req.we && mem_req.re);
   endproperty
   a_no_read_write_overlap: assert property (p_no_read_write_overlap)
      else $error("symbol memory read and written in the same cycle");

   property p_emit_order;
      @(posedge clock) disable iff (reset)
         (rsp_valid && !rsp_stall && !rsp_last) |=> (p_ff == $past(p_ff) + AddrW'(1));
   endproperty
   a_emit_order: assert property (p_emit_order)
      else $error("response position did not advance by one");

endmodule

// ----- tb/sv/next_multiset_k_permutation_test.sv -----
// self-checking testbench for the next multiset k-permutation block
module next_multiset_k_permutation_test;
   import nmkp_pkg::*;

   localparam int CycleLimit          = 2_000_000;
   localparam int SettleCycles        = 16;
   localparam int HoldCycles          = 400;
   localparam int RandomItemsPerPhase = 105;
   localparam int ArrayLimit          = (MaxElements < 64) ? MaxElements : 64;

   // one response as the block returns it
   typedef struct packed {
      logic [5:0] position;
      logic [5:0] symbol;
      logic       last;
      logic       exhausted;
   } perm_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_op = OP_LOAD;
   logic [5:0]  req_load_position = '0;
   logic [5:0]  req_load_symbol = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [5:0]  rsp_position;
   logic [5:0]  rsp_symbol;
   logic        rsp_last;
   logic        rsp_exhausted;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // shadow copy of the array and the registers
   logic [SymW-1:0] shadow_symbols [MaxElements];
   logic [CntW-1:0] shadow_total_count = 7'd64;
   logic [CntW-1:0] shadow_prefix_length = 7'd64;
   perm_result_type pending_results [$];

   int failures = 0;
   int request_count = 0;
   int send_idle_pct = 28;
   int recv_idle_pct = 50;
   int hold_requests_made = 0;

   next_multiset_k_permutation uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_load_position (req_load_position),
      .req_load_symbol   (req_load_symbol),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_position      (rsp_position),
      .rsp_symbol        (rsp_symbol),
      .rsp_last          (rsp_last),
      .rsp_exhausted     (rsp_exhausted),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always #4 clock = ~clock;

   // run limit
   initial begin
      repeat (CycleLimit) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   // permutation arithmetic on the shadow array
   function automatic void swap_entries(input int a, input int b);
      logic [SymW-1:0] t;
      t = shadow_symbols[a];
      shadow_symbols[a] = shadow_symbols[b];
      shadow_symbols[b] = t;
   endfunction

   // reverse positions lo..hi-1
   function automatic void reverse_entries(input int lo, input int hi);
      while (lo + 1 < hi) begin
         hi--;
         swap_entries(lo, hi);
         lo++;
      end
   endfunction

   // returns 1 when a next k-permutation was formed
   function automatic bit step_permutation(input int n, input int k);
      int edge_pos;
      int i;
      int j;
      edge_pos = k - 1;
      if (k < n) begin
         j = k;
         while (j < n && shadow_symbols[edge_pos] >= shadow_symbols[j]) j++;
         if (j < n) begin
            swap_entries(edge_pos, j);
            return 1'b1;
         end
         reverse_entries(k, n);
      end
      if (k < 2) return 1'b0;
      for (i = edge_pos - 1; i >= 0; i--) begin
         if (shadow_symbols[i] < shadow_symbols[i + 1]) break;
      end
      if (i < 0) return 1'b0;
      j = n - 1;
      while (j > i && shadow_symbols[i] >= shadow_symbols[j]) j--;
      swap_entries(i, j);
      reverse_entries(i + 1, n);
      return 1'b1;
   endfunction

   // clip n and k, advance, and queue the responses expected
   function automatic void predict_advance(output bit exhausted_out);
      int n;
      int k;
      perm_result_type r;
      n = shadow_total_count;
      if (n < 1) n = 1;
      if (n > ArrayLimit) n = ArrayLimit;
      k = shadow_prefix_length;
      if (k < 1) k = 1;
      if (k > n) k = n;
      exhausted_out = !step_permutation(n, k);
      if (exhausted_out) begin
         r = '{position: 6'd0, symbol: 6'd0, last: 1'b1, exhausted: 1'b1};
         pending_results.push_back(r);
      end else begin
         for (int p = 0; p < k; p++) begin
            r.position  = p[5:0];
            r.symbol    = shadow_symbols[p];
            r.last      = (p + 1 == k);
            r.exhausted = 1'b0;
            pending_results.push_back(r);
         end
      end
   endfunction

   // offer one request and wait for it to be taken
   task automatic send_request(input logic op, input logic [5:0] pos,
                               input logic [5:0] sym, output bit exhausted_seen);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_op            <= op;
      req_load_position <= pos;
      req_load_symbol   <= sym;
      do @(posedge clock); while (req_stall);
      request_count++;
      exhausted_seen = 1'b0;
      if (op == OP_LOAD) shadow_symbols[pos] = sym;
      else predict_advance(exhausted_seen);
   endtask

   task automatic load_entry(input int pos, input int sym);
      bit unused;
      send_request(OP_LOAD, pos[5:0], sym[5:0], unused);
   endtask

   task automatic advance_once(output bit exhausted_seen);
      send_request(OP_ADVANCE, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                   exhausted_seen);
   endtask

   // drop valid and let all outstanding responses drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // register write: setup then access cycle
   task automatic write_register(input logic index, input logic [31:0] value);
      wait_idle();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (index == REG_TOTAL_COUNT) shadow_total_count = value[CntW-1:0];
      else shadow_prefix_length = value[CntW-1:0];
   endtask

   task automatic configure(input logic [31:0] count_value, input logic [31:0] prefix_value);
      write_register(REG_TOTAL_COUNT, count_value);
      write_register(REG_PREFIX_LENGTH, prefix_value);
   endtask

   // load positions 0..count-1, sorted unless a broken set is wanted
   task automatic load_multiset(input int count, input int alphabet, input bit sorted);
      logic [5:0] vals [$];
      for (int p = 0; p < count; p++) vals.push_back(6'($urandom_range(0, alphabet - 1)));
      if (sorted) vals.sort();
      for (int p = 0; p < count; p++) load_entry(p, vals[p]);
   endtask

   // response checking against the oldest expectation
   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      perm_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response, expected none actual pos %0d sym %0d last %0b exh %0b",
                     $time, rsp_position, rsp_symbol, rsp_last, rsp_exhausted);
            failures++;
         end else begin
            want = pending_results.pop_front();
            compare_field("position", want.position, rsp_position);
            compare_field("symbol", want.symbol, rsp_symbol);
            compare_field("last", want.last, rsp_last);
            compare_field("exhausted", want.exhausted, rsp_exhausted);
         end
      end
   end

   // receiver: random stalls plus a long hold-off on demand
   always @(posedge clock) begin
      int hold_seen;
      int hold_left;
      if (hold_seen != hold_requests_made) begin
         hold_seen = hold_requests_made;
         hold_left = HoldCycles;
      end
      rsp_stall <= (hold_left > 0) || ($urandom_range(0, 99) < recv_idle_pct);
      if (hold_left > 0) hold_left--;
   end

   // every position written, extremes at both ends
   task automatic test_array_fill();
      for (int p = 0; p < MaxElements; p++) begin
         if (p == 0) load_entry(p, 0);
         else if (p == MaxElements - 1) load_entry(p, 63);
         else load_entry(p, $urandom_range(0, 63));
      end
   endtask

   // registers still at their reset values: full length prefix
   task automatic test_full_length_advance();
      bit ex;
      advance_once(ex);
      advance_once(ex);
   endtask

   // count and prefix saturation, upper data bits ignored
   task automatic test_register_clipping();
      bit ex;
      configure(32'd0, 32'd5);
      advance_once(ex);
      configure(32'hFFFF_FFE4, 32'd0);
      advance_once(ex);
      configure(32'd6, 32'd70);
      advance_once(ex);
   endtask

   // prefix of one: tail reversed, then exhausted; then a plain swap
   task automatic test_prefix_of_one();
      bit ex;
      configure(32'd3, 32'd1);
      load_entry(0, 5);
      load_entry(1, 3);
      load_entry(2, 4);
      advance_once(ex);
      advance_once(ex);
      load_entry(0, 1);
      advance_once(ex);
   endtask

   // walk a small multiset to exhaustion and beyond
   task automatic test_exhaustion();
      bit ex;
      configure(32'd4, 32'd2);
      load_entry(0, 0);
      load_entry(1, 0);
      load_entry(2, 1);
      load_entry(3, 1);
      repeat (5) advance_once(ex);
      configure(32'd3, 32'd3);
      load_entry(0, 2);
      load_entry(1, 1);
      load_entry(2, 0);
      advance_once(ex);
   endtask

   // random runs: mostly sorted sets walked forward, some noise and broken sets
   task automatic run_random_sequences(input int item_goal);
      int start;
      int n_cfg;
      int k_cfg;
      int n_eff;
      int alphabet;
      int steps;
      int r;
      bit ex;
      logic [31:0] count_word;
      logic [31:0] prefix_word;
      start = request_count;
      while (request_count - start < item_goal) begin
         r = $urandom_range(0, 99);
         if (r < 4) n_cfg = $urandom_range(64, 127);
         else if (r < 8) n_cfg = 0;
         else n_cfg = $urandom_range(1, 8);
         n_eff = (n_cfg < 1) ? 1 : (n_cfg > ArrayLimit) ? ArrayLimit : n_cfg;
         r = $urandom_range(0, 99);
         if (r < 5) k_cfg = 0;
         else if (r < 10) k_cfg = $urandom_range(n_eff, 127);
         else k_cfg = $urandom_range(1, n_eff);
         count_word  = n_cfg;
         prefix_word = k_cfg;
         if ($urandom_range(0, 9) == 0) count_word = ($urandom() & ~32'h7F) | n_cfg;
         if ($urandom_range(0, 9) == 0) prefix_word = ($urandom() & ~32'h7F) | k_cfg;
         configure(count_word, prefix_word);
         if (n_eff <= 16) begin
            alphabet = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 4);
            load_multiset(n_eff, alphabet, $urandom_range(0, 99) >= 20);
         end
         steps = (n_eff > 16) ? $urandom_range(1, 2) : $urandom_range(3, 24);
         for (int s = 0; s < steps; s++) begin
            if ($urandom_range(0, 99) < 8) load_entry($urandom_range(0, 63), $urandom_range(0, 63));
            advance_once(ex);
            if (ex && $urandom_range(0, 1)) break;
         end
      end
   endtask

   // receiver holds off while advances keep coming
   task automatic test_long_hold();
      bit ex;
      configure(32'd6, 32'd6);
      load_multiset(6, 3, 1'b1);
      hold_requests_made++;
      repeat (6) advance_once(ex);
   endtask

   // test sequence
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_array_fill();
      test_full_length_advance();
      test_register_clipping();
      test_prefix_of_one();
      test_exhaustion();
      run_random_sequences(RandomItemsPerPhase);
      send_idle_pct = 50;
      recv_idle_pct = 28;
      run_random_sequences(RandomItemsPerPhase);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random_sequences(RandomItemsPerPhase);
      test_long_hold();
      wait_idle();
      repeat (64) @(posedge clock);
      if (failures == 0 && pending_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
